// ===== rtl/tcpq_pkg.sv =====
// Shared constants, types and the byte classifier for the two-class priority queue.
package tcpq_pkg;

    localparam int CLASS_DEPTH = 256;
    localparam int PTR_W       = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
    localparam int FILL_W      = $clog2(CLASS_DEPTH + 1);
    localparam int CH_W        = 8;
    localparam int CNT_W       = 16;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_PUSHED  = 2'd0,
        ST_DROPPED = 2'd1,
        ST_POPPED  = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load_out;
    } tcpq_cmd_t;

    function automatic logic is_urgent(input logic [CH_W-1:0] c);
        logic r;
        case (c)
            CH_W'("a"), CH_W'("A"), CH_W'("e"), CH_W'("E"),
            CH_W'("i"), CH_W'("I"), CH_W'("o"), CH_W'("O"),
            CH_W'("u"), CH_W'("U"), CH_W'("."), CH_W'("!"): r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/tcpq_if.sv =====
// Request and response channel interfaces for the two-class priority queue.
interface tcpq_req_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] ch;

    modport source (output valid, output op, output ch, input ready);
    modport sink   (input valid, input op, input ch, output ready);
endinterface

interface tcpq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  out_char;
    logic        was_urgent;
    logic [15:0] normal_push_total;

    modport source (output valid, output status, output out_char, output was_urgent,
                    output normal_push_total, input ready);
    modport sink   (input valid, input status, input out_char, input was_urgent,
                    input normal_push_total, output ready);
endinterface

// ===== rtl/tcpq_ctrl.sv =====
// Sequencer: takes a request, runs the datapath step, hands off to the response register.
module tcpq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output tcpq_pkg::tcpq_cmd_t cmd
);
    import tcpq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } state_t;

    state_t state_reg;
    logic   ready_reg;
    logic   valid_reg;

    assign req_ready = ready_reg;
    assign rsp_valid = valid_reg;

    always_comb
    begin
        cmd.capture  = (state_reg == S_IDLE) && req_valid && ready_reg;
        cmd.exec     = (state_reg == S_EXEC);
        cmd.load_out = (state_reg == S_DONE) && (!valid_reg || rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
            valid_reg <= 1'b0;
        end
        else
        begin
            // response register drains independently; a load refills it in the same cycle
            if (cmd.load_out)
                valid_reg <= 1'b1;
            else if (valid_reg && rsp_ready)
                valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.capture)
                    begin
                        ready_reg <= 1'b0;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (cmd.load_out)
                    begin
                        ready_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (state_reg == S_IDLE))
        else $error("ready outside idle");
    a_capture_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == S_EXEC) && !ready_reg)
        else $error("capture did not start a step");
    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> valid_reg && ready_reg)
        else $error("load did not present a response");
endmodule

// ===== rtl/tcpq_dp.sv =====
// Datapath: two class stores with head/tail/fill, normal push counter, response register.
module tcpq_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tcpq_pkg::tcpq_cmd_t        cmd,
    input  logic                       op,
    input  logic [tcpq_pkg::CH_W-1:0]  ch,
    output tcpq_pkg::status_t          status,
    output logic [tcpq_pkg::CH_W-1:0]  out_char,
    output logic                       was_urgent,
    output logic [tcpq_pkg::CNT_W-1:0] normal_push_total
);
    import tcpq_pkg::*;

    logic [CH_W-1:0]   u_mem [CLASS_DEPTH];
    logic [CH_W-1:0]   n_mem [CLASS_DEPTH];

    logic              op_reg;
    logic [CH_W-1:0]   ch_reg;

    logic [PTR_W-1:0]  u_head_reg, u_head_next, u_tail_reg, u_tail_next;
    logic [PTR_W-1:0]  n_head_reg, n_head_next, n_tail_reg, n_tail_next;
    logic [FILL_W-1:0] u_fill_reg, u_fill_next, n_fill_reg, n_fill_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [CH_W-1:0]   u_rd_reg, n_rd_reg;
    status_t           st_reg, st_next;
    logic              urg_reg, urg_next;

    status_t           o_st_reg;
    logic [CH_W-1:0]   o_ch_reg;
    logic              o_urg_reg;
    logic [CNT_W-1:0]  o_cnt_reg;

    logic ch_urgent, u_full, n_full, u_wr, n_wr, u_rd, n_rd;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(CLASS_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign ch_urgent = is_urgent(ch_reg);
    assign u_full    = (u_fill_reg == FILL_W'(CLASS_DEPTH));
    assign n_full    = (n_fill_reg == FILL_W'(CLASS_DEPTH));
    assign u_wr      = cmd.exec && (op_reg == OP_PUSH) && ch_urgent && !u_full;
    assign n_wr      = cmd.exec && (op_reg == OP_PUSH) && !ch_urgent && !n_full;
    assign u_rd      = cmd.exec && (op_reg == OP_POP) && (u_fill_reg != '0);
    assign n_rd      = cmd.exec && (op_reg == OP_POP) && (u_fill_reg == '0)
                       && (n_fill_reg != '0);

    always_comb
    begin
        u_head_next = u_rd ? wrap_inc(u_head_reg) : u_head_reg;
        n_head_next = n_rd ? wrap_inc(n_head_reg) : n_head_reg;
        u_tail_next = u_wr ? wrap_inc(u_tail_reg) : u_tail_reg;
        n_tail_next = n_wr ? wrap_inc(n_tail_reg) : n_tail_reg;
        u_fill_next = u_wr ? u_fill_reg + FILL_W'(1)
                    : (u_rd ? u_fill_reg - FILL_W'(1) : u_fill_reg);
        n_fill_next = n_wr ? n_fill_reg + FILL_W'(1)
                    : (n_rd ? n_fill_reg - FILL_W'(1) : n_fill_reg);
        cnt_next    = n_wr ? cnt_reg + CNT_W'(1) : cnt_reg;
        if (op_reg == OP_PUSH)
        begin
            urg_next = ch_urgent;
            st_next  = (ch_urgent ? u_full : n_full) ? ST_DROPPED : ST_PUSHED;
        end
        else if (u_fill_reg != '0)
        begin
            urg_next = 1'b1;
            st_next  = ST_POPPED;
        end
        else if (n_fill_reg != '0)
        begin
            urg_next = 1'b0;
            st_next  = ST_POPPED;
        end
        else
        begin
            urg_next = 1'b0;
            st_next  = ST_EMPTY;
        end
    end

    // class stores, registered read at the head
    always_ff @(posedge clk)
    begin
        if (u_wr)
            u_mem[u_tail_reg] <= ch_reg;
        if (n_wr)
            n_mem[n_tail_reg] <= ch_reg;
        if (u_rd)
            u_rd_reg <= u_mem[u_head_reg];
        if (n_rd)
            n_rd_reg <= n_mem[n_head_reg];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= op;
            ch_reg <= ch;
        end
        if (cmd.exec)
        begin
            st_reg  <= st_next;
            urg_reg <= urg_next;
        end
        if (cmd.load_out)
        begin
            o_st_reg  <= st_reg;
            o_urg_reg <= urg_reg;
            o_cnt_reg <= cnt_reg;
            o_ch_reg  <= (st_reg == ST_POPPED) ? (urg_reg ? u_rd_reg : n_rd_reg) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_head_reg <= '0;
            u_tail_reg <= '0;
            u_fill_reg <= '0;
            n_head_reg <= '0;
            n_tail_reg <= '0;
            n_fill_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            u_head_reg <= u_head_next;
            u_tail_reg <= u_tail_next;
            u_fill_reg <= u_fill_next;
            n_head_reg <= n_head_next;
            n_tail_reg <= n_tail_next;
            n_fill_reg <= n_fill_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign status            = o_st_reg;
    assign out_char          = o_ch_reg;
    assign was_urgent        = o_urg_reg;
    assign normal_push_total = o_cnt_reg;

    a_u_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        u_fill_reg <= FILL_W'(CLASS_DEPTH))
        else $error("urgent fill beyond depth");
    a_n_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_fill_reg <= FILL_W'(CLASS_DEPTH))
        else $error("normal fill beyond depth");
    a_urgent_first: assert property (@(posedge clk) disable iff (!rst_n)
        !(u_rd && n_rd))
        else $error("both classes popped at once");
    a_drop_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && (op_reg == OP_PUSH) && !ch_urgent && n_full)
        |=> $stable(cnt_reg) && $stable(n_fill_reg))
        else $error("dropped normal push changed state");
endmodule

// ===== rtl/two_class_priority_char_queue_unit.sv =====
// Top level of the two-class strict-priority byte queue.
// Each request either pushes a byte (op 0) or pops one (op 1). Vowels of either case, '.' and
// '!' go to the urgent class, every other byte to the normal class; each class is a FIFO of
// CLASS_DEPTH entries held in its own memory. A pop returns the oldest urgent byte while any is
// queued, otherwise the oldest normal byte, and reports status 3 when both are empty. A push to
// a full class is dropped with status 1. Each request yields exactly one response carrying the
// status, the popped byte (zero otherwise), the class flag and the 16-bit wrapping count of
// accepted normal pushes. A request is captured at the accepting edge, the execute state then
// does the pointer update and the registered memory read, and the done state loads its response
// into the output register once that register is free; the sequencer handles one request at a
// time and raises ready again with that load, so the next request is taken only after that load.
// The response register lets the next request be accepted while a previous response still
// waits; a stalled response holds the sequence only at its load step.
// Store contents are not cleared at reset; only entries that were written are ever read.
module two_class_priority_char_queue_unit (
    input  logic       clk,
    input  logic       rst_n,
    tcpq_req_if.sink   req,
    tcpq_rsp_if.source rsp
);
    import tcpq_pkg::*;

    tcpq_cmd_t cmd;
    status_t   dp_status;

    // sequencer: owns the handshakes
    tcpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    // datapath: stores, pointers, counter and the response register
    tcpq_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .op                (req.op),
        .ch                (req.ch),
        .status            (dp_status),
        .out_char          (rsp.out_char),
        .was_urgent        (rsp.was_urgent),
        .normal_push_total (rsp.normal_push_total)
    );

    assign rsp.status = dp_status;
endmodule

// ===== sim/tb_two_class_priority_char_queue_unit.sv =====
// Testbench for the two-class priority byte queue: scoreboard, request driver and checks.
module tb_two_class_priority_char_queue_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tcpq_pkg::*;

    // Watchdog. It is many times the slowest legal run.
    localparam int CYCLE_LIMIT    = 5_000_000;
    // Receiver hold-off long enough to fill the block and stall the request side.
    localparam int HOLD_OFF_LEN   = 400;
    localparam int DRAIN_TAIL     = 20;

    localparam logic [CH_W-1:0] URGENT_SET [12] = '{"a", "A", "e", "E", "i", "I",
                                                    "o", "O", "u", "U", ".", "!"};

    typedef enum int {PICK_ANY, PICK_URGENT, PICK_NORMAL} char_kind_t;

    typedef struct {
        status_t          status;
        logic [CH_W-1:0]  out_char;
        logic             was_urgent;
        logic [CNT_W-1:0] total;
    } queue_response_t;

    // Tracks both class FIFOs and the push count, and holds the responses still owed.
    class priority_queue_tracker;
        logic [CH_W-1:0]  urgent_bytes[$];
        logic [CH_W-1:0]  normal_bytes[$];
        logic [CNT_W-1:0] normal_count;
        queue_response_t  owed[$];
        int mismatches, responses, kept, dropped, pops, empties, wraps;

        function new();
            normal_count = '0;
        endfunction

        static function bit urgent_class(logic [CH_W-1:0] c);
            return c inside {"a", "A", "e", "E", "i", "I", "o", "O", "u", "U", ".", "!"};
        endfunction

        function int urgent_held();
            return urgent_bytes.size();
        endfunction

        function int normal_held();
            return normal_bytes.size();
        endfunction

        function int outstanding();
            return owed.size();
        endfunction

        function void note_request(logic op, logic [CH_W-1:0] ch);
            queue_response_t r;
            r.out_char   = '0;
            r.was_urgent = 1'b0;
            if (op == OP_PUSH) begin
                r.was_urgent = urgent_class(ch);
                r.status     = ST_DROPPED;
                if (r.was_urgent && urgent_bytes.size() < CLASS_DEPTH) begin
                    urgent_bytes.push_back(ch);
                    r.status = ST_PUSHED;
                end else if (!r.was_urgent && normal_bytes.size() < CLASS_DEPTH) begin
                    normal_bytes.push_back(ch);
                    normal_count++;
                    if (normal_count == '0)
                        wraps++;
                    r.status = ST_PUSHED;
                end
                if (r.status == ST_PUSHED)
                    kept++;
                else
                    dropped++;
            end else if (urgent_bytes.size() > 0) begin
                r.out_char   = urgent_bytes.pop_front();
                r.was_urgent = 1'b1;
                r.status     = ST_POPPED;
                pops++;
            end else if (normal_bytes.size() > 0) begin
                r.out_char = normal_bytes.pop_front();
                r.status   = ST_POPPED;
                pops++;
            end else begin
                r.status = ST_EMPTY;
                empties++;
            end
            r.total = normal_count;
            owed.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, logic [CNT_W-1:0] got);
            if (got !== CNT_W'(want)) begin
                mismatches++;
                $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want,
                         got);
            end
        endfunction

        function void check_response(logic [1:0] status, logic [CH_W-1:0] out_char,
                                     logic was_urgent, logic [CNT_W-1:0] total);
            queue_response_t r;
            responses++;
            if (owed.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected response, expected none, actual status %0d",
                         $time, status);
                return;
            end
            r = owed.pop_front();
            compare_field("status", r.status, CNT_W'(status));
            compare_field("out_char", r.out_char, CNT_W'(out_char));
            compare_field("was_urgent", r.was_urgent, CNT_W'(was_urgent));
            compare_field("normal_push_total", r.total, total);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycles;
    priority_queue_tracker tracker;

    tcpq_req_if req_ch();
    tcpq_rsp_if rsp_ch();

    two_class_priority_char_queue_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog on a cycle count.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("Timed out after %0d cycles with %0d responses owed", cycles,
                         tracker.outstanding());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CH_W-1:0] pick_char(char_kind_t kind);
        logic [CH_W-1:0] c;
        case (kind)
            PICK_URGENT: c = URGENT_SET[$urandom_range(0, 11)];
            PICK_NORMAL:
            begin
                c = CH_W'($urandom_range(0, 255));
                while (priority_queue_tracker::urgent_class(c))
                    c = CH_W'($urandom_range(0, 255));
            end
            default: c = CH_W'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    // Offers one request, after an optional gap, and returns at the edge where it is taken.
    // valid only drops at the negedge that starts a gap, so it is never lowered and
    // raised within the same step.
    task automatic send_request(input logic op, input logic [CH_W-1:0] ch);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.ch    <= ch;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        tracker.note_request(op, ch);
    endtask

    task automatic send_random_pop();
        send_request(OP_POP, pick_char(PICK_ANY));
    endtask

    // Free mix of pushes and pops; vowels and punctuation weighted up.
    task automatic run_mixed(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 55)
                send_request(OP_PUSH, pick_char(($urandom_range(0, 99) < 40) ? PICK_URGENT
                                                                            : PICK_ANY));
            else
                send_random_pop();
        end
    endtask

    // Fills one class until it is full, pushes past it, then drains everything. A little
    // noise from the other class and stray pops keeps the priority choice busy.
    task automatic fill_and_drain(input bit urgent_side);
        char_kind_t side, other;
        int r;
        side  = urgent_side ? PICK_URGENT : PICK_NORMAL;
        other = urgent_side ? PICK_NORMAL : PICK_URGENT;
        while ((urgent_side ? tracker.urgent_held() : tracker.normal_held()) < CLASS_DEPTH)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                send_random_pop();
            else if (r < 10)
                send_request(OP_PUSH, pick_char(other));
            else
                send_request(OP_PUSH, pick_char(side));
        end
        // Full class: these are dropped and must not move the count.
        repeat (4) send_request(OP_PUSH, pick_char(side));
        send_request(OP_PUSH, pick_char(other));
        while (tracker.urgent_held() + tracker.normal_held() > 0)
        begin
            if ($urandom_range(0, 99) < 10)
                send_request(OP_PUSH, pick_char(PICK_ANY));
            else
                send_random_pop();
        end
        repeat (2) send_random_pop();
    endtask

    // Receiver: checks at the rising edge, picks ready at the falling edge. Twice it holds
    // ready low for a long stretch so the block backs up and stalls its request side.
    initial
    begin
        int gap_left;
        int hold_left;
        int hold_stage;
        gap_left   = 0;
        hold_left  = 0;
        hold_stage = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                tracker.check_response(rsp_ch.status, rsp_ch.out_char, rsp_ch.was_urgent,
                                       rsp_ch.normal_push_total);
            @(negedge clk);
            if ((hold_stage == 0 && tracker.responses >= 300) ||
                (hold_stage == 1 && tracker.responses >= 1000))
            begin
                hold_stage++;
                hold_left = HOLD_OFF_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                gap_left = pick_gap();
            end
        end
    end

    // Main sequence: reset, directed requests, a random phase, fill and drain, a random phase, drain.
    initial
    begin
        tracker      = new();
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.op    = OP_PUSH;
        req_ch.ch    = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: pop on empty, byte extremes, every urgent byte, priority over normal.
        send_request(OP_POP, 8'hFF);
        send_request(OP_PUSH, 8'h00);
        send_request(OP_PUSH, 8'hFF);
        foreach (URGENT_SET[i])
            send_request(OP_PUSH, URGENT_SET[i]);
        send_request(OP_POP, 8'h00);
        send_request(OP_PUSH, "b");
        repeat (4) send_request(OP_POP, 8'h5A);

        run_mixed(150);
        fill_and_drain(1'b1);
        fill_and_drain(1'b0);
        run_mixed(250);

        @(negedge clk);
        req_ch.valid <= 1'b0;

        // Let every owed response arrive, then wait out the drain tail for anything stray.
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("Ran %0d requests: %0d pushes kept, %0d dropped on a full class, %0d pops,",
                 tracker.kept + tracker.dropped + tracker.pops + tracker.empties,
                 tracker.kept, tracker.dropped, tracker.pops);
        $display("%0d pops on empty, push count wrapped %0d time(s), %0d mismatch(es)",
                 tracker.empties, tracker.wraps, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tcpq_pkg.sv
rtl/tcpq_if.sv
rtl/tcpq_ctrl.sv
rtl/tcpq_dp.sv
rtl/two_class_priority_char_queue_unit.sv
sim/tb_two_class_priority_char_queue_unit.sv
